// File: hw/rtl/olads_pkg.sv
// Package with the shared constants, codes and control structs of the ordered list core.
`default_nettype none

package olads_pkg;

	localparam int LIST_DEPTH = 64;
	localparam int IDX_W = $clog2(LIST_DEPTH);
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int POS_W = 8;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 3;
	localparam int LEN_W = 7;
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef logic [FUNC_W-1:0] func_t;

	localparam func_t FN_APPEND = 2'd0;
	localparam func_t FN_DELETE = 2'd1;
	localparam func_t FN_SEARCH = 2'd2;

	typedef logic [STAT_W-1:0] status_t;

	localparam status_t ST_OK = 3'd0;
	localparam status_t ST_EMPTY = 3'd1;
	localparam status_t ST_POS_LOW = 3'd2;
	localparam status_t ST_POS_HIGH = 3'd3;
	localparam status_t ST_FULL = 3'd4;

	typedef struct packed {
		logic    ready;
		logic    cap;
		logic    app;
		logic    idx_pos;
		logic    idx_zero;
		logic    idx_inc;
		logic    rd_en;
		logic    rd_next;
		logic    wr_shift;
		logic    dec_cnt;
		logic    res_load;
		status_t res_status;
		logic    set_found;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		logic  req_valid;
		func_t func;
		logic  cnt_zero;
		logic  full;
		logic  pos_zero;
		logic  pos_high;
		logic  last;
		logic  match;
		logic  out_free;
	} stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/olads_req_if.sv
// Request channel interface carrying one list operation per item.
`default_nettype none

interface olads_req_if;
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic signed [31:0]  item_value;
	logic [7:0]          position;

	modport source (output valid, output func, output item_value, output position,
		input ready);
	modport sink (input valid, input func, input item_value, input position,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/olads_rsp_if.sv
// Response channel interface carrying one result per item.
`default_nettype none

interface olads_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       found;
	logic [6:0] list_length;

	modport source (output valid, output status, output found, output list_length,
		input ready);
	modport sink (input valid, input status, input found, input list_length,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/olads_ctrl.sv
// Controller state machine that sequences append, delete and search over the list memory.
`default_nettype none

module olads_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  olads_pkg::stat_t st,
	output olads_pkg::cmd_t  cmd
);
	import olads_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_DRD  = 3'd2;
	localparam logic [2:0] S_DWR  = 3'd3;
	localparam logic [2:0] S_SRD  = 3'd4;
	localparam logic [2:0] S_SCMP = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.res_status = ST_OK;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (st.req_valid) begin
					cmd.cap = 1'b1;
					state_nxt = S_DEC;
				end
			end
			S_DEC: begin
				cmd.res_load = 1'b1;
				unique case (st.func)
					FN_APPEND: begin
						if (st.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.app = 1'b1;
						end
						state_nxt = S_FIN;
					end
					FN_DELETE: begin
						priority if (st.cnt_zero) begin
							cmd.res_status = ST_EMPTY;
							state_nxt = S_FIN;
						end else if (st.pos_zero) begin
							cmd.res_status = ST_POS_LOW;
							state_nxt = S_FIN;
						end else if (st.pos_high) begin
							cmd.res_status = ST_POS_HIGH;
							state_nxt = S_FIN;
						end else begin
							cmd.idx_pos = 1'b1;
							state_nxt = S_DRD;
						end
					end
					FN_SEARCH: begin
						cmd.idx_zero = 1'b1;
						state_nxt = st.cnt_zero ? S_FIN : S_SRD;
					end
					default: begin
						state_nxt = S_FIN;
					end
				endcase
			end
			S_DRD: begin
				if (st.last) begin
					cmd.dec_cnt = 1'b1;
					state_nxt = S_FIN;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_next = 1'b1;
					state_nxt = S_DWR;
				end
			end
			S_DWR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_inc = 1'b1;
				state_nxt = S_DRD;
			end
			S_SRD: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_SCMP;
			end
			S_SCMP: begin
				priority if (st.match) begin
					cmd.set_found = 1'b1;
					state_nxt = S_FIN;
				end else if (st.last) begin
					state_nxt = S_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt = S_SRD;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/olads_dp.sv
// Datapath with the list memory, entry count, index, result and output registers.
`default_nettype none

module olads_dp (
	input  logic             clk,
	input  logic             arst_n,
	olads_req_if.sink        req,
	olads_rsp_if.source      rsp,
	input  olads_pkg::cmd_t  cmd,
	output olads_pkg::stat_t st
);
	import olads_pkg::*;

	logic [VAL_W-1:0] mem [LIST_DEPTH];

	func_t            func_q;
	logic [VAL_W-1:0] val_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [VAL_W-1:0] rd_q;
	status_t          res_status_q;
	logic             res_found_q;
	logic             rsp_valid_q;
	status_t          rsp_status_q;
	logic             rsp_found_q;
	logic [LEN_W-1:0] rsp_len_q;

	logic [CNT_W-1:0] idx_plus;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;

	assign idx_plus = CNT_W'(idx_q) + CNT_W'(1);
	assign rd_addr = cmd.rd_next ? idx_plus[IDX_W-1:0] : idx_q;
	assign wr_addr = cmd.app ? cnt_q[IDX_W-1:0] : idx_q;
	assign wr_data = cmd.app ? val_q : rd_q;

	assign req.ready = cmd.ready;

	assign st.req_valid = req.valid;
	assign st.func = func_q;
	assign st.cnt_zero = (cnt_q == '0);
	assign st.full = (cnt_q >= CNT_W'(LIST_DEPTH));
	assign st.pos_zero = (pos_q == '0);
	assign st.pos_high = (CMP_W'(pos_q) > CMP_W'(cnt_q));
	assign st.last = (idx_plus >= cnt_q);
	assign st.match = (rd_q == val_q);
	assign st.out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q <= req.func;
			val_q <= $unsigned(req.item_value);
			pos_q <= req.position;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.app || cmd.wr_shift) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.app) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.dec_cnt) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.idx_pos) begin
			idx_q <= IDX_W'(pos_q - POS_W'(1));
		end else if (cmd.idx_zero) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_plus[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_found_q <= 1'b0;
		end else if (cmd.set_found) begin
			res_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_status_q <= res_status_q;
			rsp_found_q <= res_found_q;
			rsp_len_q <= LEN_W'(cnt_q);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.found = rsp_found_q;
	assign rsp.list_length = rsp_len_q;

endmodule

`default_nettype wire

// File: hw/rtl/ordered_list_append_delete_search_core.sv
// Top level of the ordered list core with append, delete and search operations.
// Append, refused delete and unused codes go from decode straight to the finish state.
// A search compares the entries in order from the first and stops at the first match or last entry.
// A delete at position p moves each entry after p down by one place (one read, one write per entry).
// One item is in work at a time; the next is accepted once the result sits in the output register.
// Reset clears the entry count and the output valid; list entries are not cleared.
`default_nettype none

module ordered_list_append_delete_search_core (
	input  logic        clk,
	input  logic        arst_n,
	olads_req_if.sink   req,
	olads_rsp_if.source rsp
);
	import olads_pkg::*;

	cmd_t  cmd;
	stat_t st;

	olads_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	olads_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.st     (st)
	);

endmodule

`default_nettype wire

// File: hw/rtl/olads_checker.sv
// Port-level checker for the ordered list core and its bind to the top level.
`default_nettype none

module olads_checker (
	input logic       clk,
	input logic       arst_n,
	olads_req_if.sink req,
	olads_rsp_if.source rsp
);
	import olads_pkg::*;

	// A stalled result keeps its valid and payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status)
			&& $stable(rsp.found) && $stable(rsp.list_length))
		else $error("result changed while stalled");

	// The core works on one item at a time, so ready drops after an accepted item.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("item accepted while another is in work");

	// A new result is only produced while the core is busy with an item.
	a_rsp_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> !$past(req.ready))
		else $error("result produced without an item in work");

	// A found flag only comes with an ok status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> rsp.status == ST_OK)
		else $error("found flag with an error status");

	// Status codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.status == ST_OK || rsp.status == ST_EMPTY
			|| rsp.status == ST_POS_LOW || rsp.status == ST_POS_HIGH
			|| rsp.status == ST_FULL)
		else $error("undefined status code");

endmodule

bind ordered_list_append_delete_search_core olads_checker u_olads_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

`default_nettype wire

// File: sim/ordered_list_append_delete_search_core_tb.sv
// Self-checking testbench for the ordered list core: random append, delete and search traffic.
`default_nettype none

module ordered_list_append_delete_search_core_tb;
	import olads_pkg::*;

	localparam func_t FN_UNUSED = 2'd3;
	localparam int MODE_FILL = 0;
	localparam int MODE_MIX = 1;
	localparam int MODE_DRAIN = 2;
	localparam int RANDOM_OPS = 1075;
	localparam int PHASE_LEN = 150;
	localparam int SETTLE_CYCLES = 200;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		func_t                    func;
		logic signed [VAL_W-1:0]  value;
		logic [POS_W-1:0]         pos;
		int                       gap;
		bit                       hold;
	} list_op_t;

	typedef struct {
		status_t           status;
		logic              found;
		logic [LEN_W-1:0]  len;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n;

	olads_req_if req_ch ();
	olads_rsp_if rsp_ch ();

	ordered_list_append_delete_search_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	list_op_t pending_ops[$];
	list_result_t expected_results[$];
	logic signed [VAL_W-1:0] shadow_list [LIST_DEPTH];
	int shadow_len = 0;
	logic signed [VAL_W-1:0] recent_values [16];
	int recent_wr = 0;
	bit steady = 1'b0;
	int issued_count = 0;
	int checked_count = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int idle_left = 0;
	int stall_left = 0;
	list_op_t next_op;
	list_result_t want;

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [VAL_W-1:0] pool_value(int k);
		case (k)
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h0000_0001;
			5: return 32'h5555_5555;
			6: return 32'hAAAA_AAAA;
			default: return 32'h0000_002A;
		endcase
	endfunction

	function automatic list_result_t apply_list_op(func_t fn, logic signed [VAL_W-1:0] val,
		logic [POS_W-1:0] pos);
		list_result_t r;
		int i;
		r.status = ST_OK;
		r.found = 1'b0;
		case (fn)
			FN_APPEND: begin
				if (shadow_len >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_list[shadow_len] = val;
					shadow_len++;
				end
			end
			FN_DELETE: begin
				if (shadow_len == 0) begin
					r.status = ST_EMPTY;
				end else if (pos == '0) begin
					r.status = ST_POS_LOW;
				end else if (int'(pos) > shadow_len) begin
					r.status = ST_POS_HIGH;
				end else begin
					for (i = int'(pos) - 1; i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i + 1];
					shadow_len--;
				end
			end
			FN_SEARCH: begin
				for (i = 0; i < shadow_len; i++)
					if (shadow_list[i] == val)
						r.found = 1'b1;
			end
			default: begin
			end
		endcase
		r.len = LEN_W'(shadow_len);
		return r;
	endfunction

	task automatic push_op(func_t fn, logic signed [VAL_W-1:0] val, logic [POS_W-1:0] pos,
		bit hold);
		list_op_t op;
		op.func = fn;
		op.value = val;
		op.pos = pos;
		op.gap = steady ? 0 : pick_idle();
		op.hold = hold;
		pending_ops.push_back(op);
		if (fn == FN_APPEND) begin
			recent_values[recent_wr] = val;
			recent_wr = (recent_wr + 1) % 16;
		end
	endtask

	// Request side: items leave the queue in order, with the planned gap before each one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.func <= '0;
			req_ch.item_value <= '0;
			req_ch.position <= '0;
			idle_left <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_results.push_back(apply_list_op(req_ch.func, req_ch.item_value,
					req_ch.position));
				issued_count <= issued_count + 1;
			end
			if (req_ch.valid && !req_ch.ready) begin
			end else if (idle_left != 0) begin
				req_ch.valid <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (pending_ops.size() == 0 || (pending_ops[0].hold &&
				issued_count + int'(req_ch.valid && req_ch.ready) != checked_count)) begin
				req_ch.valid <= 1'b0;
			end else if (pending_ops[0].gap != 0) begin
				req_ch.valid <= 1'b0;
				idle_left <= pending_ops[0].gap - 1;
				pending_ops[0].gap = 0;
			end else begin
				next_op = pending_ops.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.func <= next_op.func;
				req_ch.item_value <= next_op.value;
				req_ch.position <= next_op.pos;
			end
		end
	end

	// Response side: random back-pressure, and each item is checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				checked_count <= checked_count + 1;
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d found %0d list_length %0d",
						rsp_ch.status, rsp_ch.found, rsp_ch.list_length);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						fail_count++;
					end
					if (rsp_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp_ch.found);
						fail_count++;
					end
					if (rsp_ch.list_length !== want.len) begin
						$error("list_length: expected %0d, got %0d", want.len,
							rsp_ch.list_length);
						fail_count++;
					end
				end
			end
			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if ((cycle_count / 900) % 3 == 0) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				stall_left <= pick_idle();
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		int roll;
		int plan_len;
		int mode;
		func_t fn;
		logic signed [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = '0;
		req_ch.item_value = '0;
		req_ch.position = '0;
		rsp_ch.ready = 1'b0;
		for (n = 0; n < 16; n++)
			recent_values[n] = '0;

		// Directed part: refusals on an empty list, value extremes, and every delete check.
		push_op(FN_SEARCH, 32'h0000_0000, 8'd0, 1'b0);
		push_op(FN_DELETE, 32'h0000_0000, 8'd1, 1'b0);
		push_op(FN_DELETE, 32'h0000_0000, 8'd0, 1'b0);
		push_op(FN_UNUSED, 32'h0000_0000, 8'd0, 1'b0);
		push_op(FN_APPEND, 32'h8000_0000, 8'd0, 1'b0);
		push_op(FN_APPEND, 32'h7FFF_FFFF, 8'd0, 1'b0);
		push_op(FN_APPEND, 32'h0000_0000, 8'd0, 1'b0);
		push_op(FN_APPEND, 32'hFFFF_FFFF, 8'd255, 1'b0);
		push_op(FN_SEARCH, 32'h8000_0000, 8'd0, 1'b0);
		push_op(FN_SEARCH, 32'hFFFF_FFFF, 8'd0, 1'b0);
		push_op(FN_SEARCH, 32'h0001_2345, 8'd0, 1'b0);
		push_op(FN_DELETE, 32'h0000_0000, 8'd0, 1'b0);
		push_op(FN_DELETE, 32'h0000_0000, 8'd5, 1'b0);
		push_op(FN_DELETE, 32'hFFFF_FFFF, 8'd255, 1'b0);
		push_op(FN_DELETE, 32'h0000_0000, 8'd4, 1'b0);
		push_op(FN_SEARCH, 32'hFFFF_FFFF, 8'd0, 1'b0);
		push_op(FN_DELETE, 32'h0000_0000, 8'd1, 1'b0);
		push_op(FN_SEARCH, 32'h7FFF_FFFF, 8'd0, 1'b0);
		push_op(FN_UNUSED, 32'hFFFF_FFFF, 8'd255, 1'b0);
		push_op(FN_APPEND, 32'h5555_5555, 8'd0, 1'b0);
		push_op(FN_APPEND, 32'hAAAA_AAAA, 8'd0, 1'b0);
		push_op(FN_DELETE, 32'h0000_0000, 8'd2, 1'b0);
		push_op(FN_SEARCH, 32'h5555_5555, 8'd0, 1'b1);
		push_op(FN_SEARCH, 32'hAAAA_AAAA, 8'd0, 1'b0);
		plan_len = 3;

		// Random part: fill, mixed and drain phases so the list swings between empty and full.
		for (n = 0; n < RANDOM_OPS; n++) begin
			if (n % PHASE_LEN == 0)
				steady = ($urandom_range(0, 3) == 0);
			case ((n / PHASE_LEN) % 4)
				0: mode = MODE_FILL;
				2: mode = MODE_DRAIN;
				default: mode = MODE_MIX;
			endcase
			roll = $urandom_range(0, 99);
			if (roll >= 97)
				fn = FN_UNUSED;
			else if (mode == MODE_FILL)
				fn = (roll < 75) ? FN_APPEND : (roll < 85) ? FN_SEARCH : FN_DELETE;
			else if (mode == MODE_DRAIN)
				fn = (roll < 20) ? FN_APPEND : (roll < 40) ? FN_SEARCH : FN_DELETE;
			else
				fn = (roll < 40) ? FN_APPEND : (roll < 65) ? FN_SEARCH : FN_DELETE;

			roll = $urandom_range(0, 9);
			if (fn == FN_SEARCH && roll < 6)
				val = recent_values[$urandom_range(0, 15)];
			else if (roll < 4)
				val = pool_value($urandom_range(0, 7));
			else
				val = $urandom;

			roll = $urandom_range(0, 9);
			if (fn == FN_DELETE && roll < 8 && plan_len > 0)
				pos = POS_W'($urandom_range(1, plan_len));
			else if (fn == FN_DELETE && roll == 8)
				pos = '0;
			else
				pos = POS_W'($urandom_range(0, 255));

			if (fn == FN_APPEND && plan_len < LIST_DEPTH)
				plan_len++;
			else if (fn == FN_DELETE && pos != '0 && int'(pos) <= plan_len)
				plan_len--;
			push_op(fn, val, pos, n == RANDOM_OPS / 2);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || req_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/olads_pkg.sv
hw/rtl/olads_req_if.sv
hw/rtl/olads_rsp_if.sv
hw/rtl/olads_ctrl.sv
hw/rtl/olads_dp.sv
hw/rtl/ordered_list_append_delete_search_core.sv
hw/rtl/olads_checker.sv
sim/ordered_list_append_delete_search_core_tb.sv
